@@ rtl/kfc_pkg.sv @@
package kfc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int NUM_BANKS   = 4;
  localparam int BANK_W      = $clog2(NUM_BANKS);
  localparam int ADDR_W      = 8;
  localparam int IDX_W       = 9;
  localparam int OUT_W       = 32;

  // mono, di, tri, tetra
  localparam int BANK_DEPTH [NUM_BANKS] = '{4, 16, 64, 256};
  localparam logic [IDX_W-1:0] BANK_BASE [NUM_BANKS] = '{9'd0, 9'd4, 9'd20, 9'd84};
  localparam logic [IDX_W-1:0] IDX_END = 9'd340;

  localparam logic [1:0] KIND_FEED  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_T = 8'h54;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_G = 2'd1;
  localparam logic [1:0] CODE_C = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       base_char;
    logic             seq_start;
    logic [IDX_W-1:0] counter_index;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] count_value;
    logic [IDX_W-1:0] index_echo;
  } out_t;

  // one issue slot toward the counter banks
  typedef struct packed {
    logic [NUM_BANKS-1:0]             bump;
    logic [NUM_BANKS-1:0][ADDR_W-1:0] addr;
    logic                             rd;
    logic [BANK_W-1:0]                rd_bank;
    logic                             clear;
  } req_t;

endpackage

@@ rtl/kfc_ram.sv @@
module kfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/kfc_seq.sv @@
module kfc_seq (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  kfc_pkg::in_t in_data,
  input  logic         both_strands,
  input  logic         out_free,
  output kfc_pkg::req_t req,
  output logic         rd_oor
);
  import kfc_pkg::*;

  logic            phase;
  logic            phase_next;
  req_t            rc_req;
  logic [2:0][1:0] hist;
  logic [2:0]      hvld;

  logic            accept;
  logic            code_ok;
  logic [1:0]      j, k, m, n;
  logic [2:0]      hv;
  req_t            fwd, rc, rd_req, clr_req;
  logic [BANK_W-1:0] bank_sel;

  always_comb begin
    code_ok = 1'b1;
    j       = CODE_A;
    unique case (in_data.base_char)
      CHAR_A:  j = CODE_A;
      CHAR_G:  j = CODE_G;
      CHAR_C:  j = CODE_C;
      CHAR_T:  j = CODE_T;
      default: code_ok = 1'b0;
    endcase
  end

  assign hv = in_data.seq_start ? 3'b000 : hvld;
  assign k  = hist[0];
  assign m  = hist[1];
  assign n  = hist[2];

  always_comb begin
    fwd = '0;
    fwd.bump = {code_ok & hv[0] & hv[1] & hv[2], code_ok & hv[0] & hv[1],
                code_ok & hv[0], code_ok};
    fwd.addr[0] = ADDR_W'(j);
    fwd.addr[1] = ADDR_W'({k, j});
    fwd.addr[2] = ADDR_W'({m, k, j});
    fwd.addr[3] = ADDR_W'({n, m, k, j});

    // reverse complement: complement each code, reverse the order
    rc = '0;
    rc.bump    = fwd.bump & {NUM_BANKS{both_strands}};
    rc.addr[0] = ADDR_W'(~j);
    rc.addr[1] = ADDR_W'({~j, ~k});
    rc.addr[2] = ADDR_W'({~j, ~k, ~m});
    rc.addr[3] = ADDR_W'({~j, ~k, ~m, ~n});
  end

  always_comb begin
    priority if (in_data.counter_index < BANK_BASE[1]) begin
      bank_sel = BANK_W'(0);
    end else if (in_data.counter_index < BANK_BASE[2]) begin
      bank_sel = BANK_W'(1);
    end else if (in_data.counter_index < BANK_BASE[3]) begin
      bank_sel = BANK_W'(2);
    end else begin
      bank_sel = BANK_W'(3);
    end
  end

  always_comb begin
    rd_req = '0;
    rd_req.rd      = 1'b1;
    rd_req.rd_bank = bank_sel;
    for (int b = 0; b < NUM_BANKS; b++) begin
      rd_req.addr[b] = ADDR_W'(in_data.counter_index - BANK_BASE[b]);
    end
    clr_req = '0;
    clr_req.clear = 1'b1;
  end

  assign rd_oor   = in_data.counter_index >= IDX_END;
  assign in_ready = !phase && (in_data.kind != KIND_READ || out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    req = '0;
    priority if (phase) begin
      req = rc_req;
    end else if (accept) begin
      unique case (in_data.kind)
        KIND_FEED:  req = fwd;
        KIND_READ:  req = rd_req;
        KIND_CLEAR: req = clr_req;
        default:    req = '0;
      endcase
    end else begin
      req = '0;
    end
  end

  assign phase_next = accept && in_data.kind == KIND_FEED && code_ok && both_strands;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      hvld  <= 3'b000;
      hist  <= '0;
    end else begin
      phase <= phase_next;
      if (accept && in_data.kind == KIND_FEED) begin
        hvld <= {hv[1], hv[0], code_ok};
        hist <= {hist[1], hist[0], j};
      end
    end
  end

  always_ff @(posedge clk) begin
    rc_req <= rc;
  end

  a_rc_one_cycle: assert property (@(posedge clk) disable iff (rst)
    phase |=> !phase) else $error("second strand slot lasted two cycles");
  a_rc_has_mono: assert property (@(posedge clk) disable iff (rst)
    phase |-> rc_req.bump[0]) else $error("second strand slot without mono bump");

endmodule

@@ rtl/kfc_cnt.sv @@
module kfc_cnt (
  input  logic           clk,
  input  logic           rst,
  input  kfc_pkg::req_t  req,
  output logic           rd_valid,
  output kfc_pkg::count_t rd_value
);
  import kfc_pkg::*;

  logic              s1_rd;
  logic [BANK_W-1:0] s1_bank;
  logic              s1_clear;
  logic              p_clear;
  logic [NUM_BANKS-1:0] s1_bump_v;
  count_t            bank_cur [NUM_BANKS];

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    localparam int D  = BANK_DEPTH[g];
    localparam int AW = $clog2(D);

    logic          re;
    logic [AW-1:0] raddr;
    logic [AW-1:0] s1_addr;
    logic [AW-1:0] p_addr;
    logic [D-1:0]  vld;
    logic          vld_q;
    logic          s1_bump;
    logic          p_we;
    count_t        rdata;
    count_t        cur;
    count_t        nxt;
    count_t        p_val;

    assign re    = req.bump[g] || (req.rd && req.rd_bank == BANK_W'(g));
    assign raddr = req.addr[g][AW-1:0];

    // the write of the previous cycle is not yet in the read data
    always_comb begin
      priority if (p_clear) begin
        cur = '0;
      end else if (p_we && p_addr == s1_addr) begin
        cur = p_val;
      end else if (vld_q) begin
        cur = rdata;
      end else begin
        cur = '0;
      end
    end

    assign nxt = (cur == '1) ? cur : cur + count_t'(1);

    kfc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(D)) u_ram (
      .clk   (clk),
      .we    (s1_bump),
      .waddr (s1_addr),
      .wdata (nxt),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        s1_bump <= 1'b0;
        p_we    <= 1'b0;
        vld     <= '0;
      end else begin
        s1_bump <= req.bump[g];
        p_we    <= s1_bump;
        if (s1_clear) begin
          vld <= '0;
        end else if (s1_bump) begin
          vld[s1_addr] <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      s1_addr <= raddr;
      vld_q   <= vld[raddr];
      p_addr  <= s1_addr;
      p_val   <= nxt;
    end

    assign bank_cur[g]  = cur;
    assign s1_bump_v[g] = s1_bump;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_rd    <= 1'b0;
      s1_clear <= 1'b0;
      p_clear  <= 1'b0;
    end else begin
      s1_rd    <= req.rd;
      s1_clear <= req.clear;
      p_clear  <= s1_clear;
    end
  end

  always_ff @(posedge clk) begin
    s1_bank <= req.rd_bank;
  end

  assign rd_valid = s1_rd;
  assign rd_value = bank_cur[s1_bank];

  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    s1_clear |-> !s1_rd && s1_bump_v == '0) else $error("clear shares a slot");
  a_read_alone: assert property (@(posedge clk) disable iff (rst)
    s1_rd |-> s1_bump_v == '0) else $error("read shares a slot with a bump");

endmodule

@@ rtl/kmer_frequency_counter_unit.sv @@
// k-mer frequency counter: histograms of 1- to 4-mers over a stream of bases.
// in channel (in_valid/in_ready/in_data) takes requests of three kinds:
//   feed a base, read one counter by index, clear all counters.
// cfg channel (cfg_valid/cfg_ready/cfg_data) writes both_strands; always ready.
// out channel (out_valid/out_ready/out_data) returns one item per read request.
// counters live in four dual-port banks (4/16/64/256 words), updated by
// read-modify-write with forwarding from the previous cycle's write.
// a feed issues its forward bumps and, when both_strands is set and the base is
// valid, an extra issue slot that bumps the reverse complement counters; a clear
// acts through per-entry valid bits, so no sweep is needed.
// a read request occupies the issue slot once; its result is registered in the
// bank read stage and then in the output register. a new read is taken only
// when the output register will be free, so not while a read is in flight.
// a stalled receiver holds off further reads only; feeds and clears go on.
// reset zeroes all counters and the base history and sets both_strands.
module kmer_frequency_counter_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  kfc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kfc_pkg::out_t  out_data
);
  import kfc_pkg::*;

  logic             both_strands;
  logic             out_free;
  logic             rd_oor;
  logic             rd_valid;
  count_t           rd_value;
  req_t             req;
  logic             s1_oor;
  logic [IDX_W-1:0] s1_idx;
  logic [63:0]      wide;
  logic [OUT_W-1:0] sat_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      both_strands <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      both_strands <= cfg_data;
    end
  end

  assign out_free = !rd_valid && (!out_valid || out_ready);

  kfc_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .both_strands (both_strands),
    .out_free     (out_free),
    .req          (req),
    .rd_oor       (rd_oor)
  );

  kfc_cnt u_cnt (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_valid (rd_valid),
    .rd_value (rd_value)
  );

  always_ff @(posedge clk) begin
    s1_oor <= rd_oor;
    s1_idx <= in_data.counter_index;
  end

  assign wide      = 64'(rd_value);
  assign sat_value = s1_oor ? '0 :
                     (wide > 64'hFFFF_FFFF) ? '1 : wide[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      out_data.count_value <= sat_value;
      out_data.index_echo  <= s1_idx;
    end
  end

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> !out_valid) else $error("read result would overwrite output");

endmodule
